@@ hdl/ctip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctip_pkg
// Shared types, widths and codes for the cubic table interpolator.
// ----------------------------------------------------------------------------
package ctip_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 512;

    localparam int DATA_W      = 32;
    localparam int ENTRY_IDX_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int QBITS       = 27;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int R_W         = PROD_W - 47;
    localparam int RIDX_W      = R_W + 1;
    localparam int PW          = QBITS + 1;
    localparam int TW          = QBITS + 3;
    localparam int WW          = QBITS + 1;
    localparam int ACC_W       = 62;
    localparam int NTAPS       = 4;

    localparam logic [DATA_W-1:0] SCALE_RESET = 32'd1048576;

    // floor(n / 3) = (n * DIV3_RECIP) >> DIV3_SHIFT for any 32-bit n
    localparam logic [DATA_W-1:0] DIV3_RECIP = 32'hAAAA_AAAB;
    localparam int                DIV3_SHIFT = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic
    {
        MODE_EVEN    = 1'b0,
        MODE_GENERAL = 1'b1
    } mode_t;

    typedef struct packed
    {
        op_t                      op;
        logic [ENTRY_IDX_W-1:0]   entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] sample;
    } item_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] value;
        logic                     out_of_range;
    } result_t;

    // table access word leaving the address stage
    typedef struct packed
    {
        logic                   valid;
        op_t                    op;
        logic [ENTRY_IDX_W-1:0] wr_index;
        logic [DATA_W-1:0]      wr_value;
    } tbl_ctl_t;

    typedef struct packed
    {
        logic valid;
        logic oor;
    } eval_ctl_t;

endpackage

@@ hdl/ctip_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctip_front
// Input register, offset and magnitude, scale multiply, index and fraction
// split, neighbor address generation with clamping.
// ----------------------------------------------------------------------------
module ctip_front
    import ctip_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         item_valid,
    input  item_t                        item,
    input  mode_t                        mode,
    input  logic [DATA_W-1:0]            scale,
    input  logic signed [DATA_W-1:0]     offset,
    output tbl_ctl_t                     ctl,
    output logic [QBITS-1:0]             t,
    output logic                         oor,
    output logic [NTAPS-1:0][IDX_W-1:0]  addr
);

    localparam logic [RIDX_W-1:0] DEPTH_R   = RIDX_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);

    logic                          s1_valid_reg;
    item_t                         s1_item_reg;
    tbl_ctl_t                      s2_ctl_reg;
    tbl_ctl_t                      s3_ctl_reg;
    tbl_ctl_t                      s4_ctl_reg;
    tbl_ctl_t                      s5_ctl_reg;
    logic [DATA_W:0]               s2_mag_reg;
    logic [PROD_W-1:0]             s3_prod_reg;
    logic                          s3_hi_reg;
    logic [R_W-1:0]                s4_r_reg;
    logic [QBITS-1:0]              s4_t_reg;
    logic [QBITS-1:0]              s5_t_reg;
    logic [NTAPS-1:0][IDX_W-1:0]   s5_addr_reg;
    logic                          s5_oor_reg;

    tbl_ctl_t                      s2_ctl_next;
    logic signed [DATA_W:0]        off_ext;
    logic signed [DATA_W:0]        s_sum;
    logic [DATA_W:0]               mag_next;
    logic [PROD_W-1:0]             prod_next;
    logic [PROD_W-1:0]             c_next;
    logic [RIDX_W-1:0]             r_ext;
    logic [NTAPS-1:0][RIDX_W-1:0]  idx;
    logic [NTAPS-1:0]              over;
    logic [NTAPS-1:0][IDX_W-1:0]   addr_next;

    assign s2_ctl_next = '{valid:    s1_valid_reg,
                           op:       s1_item_reg.op,
                           wr_index: s1_item_reg.entry_index,
                           wr_value: s1_item_reg.entry_value};

    // x, or x + offset in general mode, then |.|
    assign off_ext  = (mode == MODE_GENERAL) ? (DATA_W+1)'(offset) : '0;
    assign s_sum    = (DATA_W+1)'($signed(s1_item_reg.sample)) + off_ext;
    assign mag_next = s_sum[DATA_W] ? (DATA_W+1)'(-s_sum) : (DATA_W+1)'(s_sum);

    // |s| * scale, top magnitude bit folded in on the next stage
    assign prod_next = PROD_W'(s2_mag_reg[DATA_W-1:0]) * PROD_W'(scale);
    assign c_next    = s3_prod_reg + (s3_hi_reg ? {scale, {DATA_W{1'b0}}} : '0);

    always_comb
    begin
        r_ext = RIDX_W'(s4_r_reg);
        if (mode == MODE_GENERAL)
        begin
            idx[0] = r_ext + RIDX_W'(1);
            idx[1] = r_ext + RIDX_W'(2);
            idx[2] = r_ext + RIDX_W'(3);
            idx[3] = r_ext + RIDX_W'(4);
        end
        else
        begin
            // left neighbor of index zero mirrors entry one
            idx[0] = (r_ext == '0) ? RIDX_W'(1) : r_ext - RIDX_W'(1);
            idx[1] = r_ext;
            idx[2] = r_ext + RIDX_W'(1);
            idx[3] = r_ext + RIDX_W'(2);
        end
        for (int k = 0; k < NTAPS; k++)
        begin
            over[k]      = (idx[k] >= DEPTH_R);
            addr_next[k] = over[k] ? LAST_ADDR : idx[k][IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_ctl_reg   <= '0;
            s3_ctl_reg   <= '0;
            s4_ctl_reg   <= '0;
            s5_ctl_reg   <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= item_valid;
            s2_ctl_reg   <= s2_ctl_next;
            s3_ctl_reg   <= s2_ctl_reg;
            s4_ctl_reg   <= s3_ctl_reg;
            s5_ctl_reg   <= s4_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= item;
            s2_mag_reg  <= mag_next;
            s3_prod_reg <= prod_next;
            s3_hi_reg   <= s2_mag_reg[DATA_W];
            s4_r_reg    <= c_next[PROD_W-1 -: R_W];
            s4_t_reg    <= c_next[PROD_W-R_W-1 -: QBITS];
            s5_t_reg    <= s4_t_reg;
            s5_addr_reg <= addr_next;
            s5_oor_reg  <= |over;
        end
    end

    assign ctl  = s5_ctl_reg;
    assign t    = s5_t_reg;
    assign oor  = s5_oor_reg;
    assign addr = s5_addr_reg;

endmodule

@@ hdl/ctip_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctip_table
// Sample table held in four identical copies, one read port each, so all
// four neighbors are read in the same cycle. Writes go to every copy.
// ----------------------------------------------------------------------------
module ctip_table
    import ctip_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  logic                        clk,
    input  logic                        en,
    input  tbl_ctl_t                    ctl,
    input  logic [NTAPS-1:0][IDX_W-1:0] addr,
    output logic [DATA_W-1:0]           f [NTAPS]
);

    localparam logic [RIDX_W-1:0] DEPTH_R = RIDX_W'(TABLE_DEPTH);

    logic [RIDX_W-1:0] wr_ext;
    logic              wr_en;
    logic [DATA_W-1:0] rd_reg [NTAPS];

    // writes past the table are dropped
    assign wr_ext = RIDX_W'(ctl.wr_index);
    assign wr_en  = en && ctl.valid && (ctl.op == OP_WRITE) && (wr_ext < DEPTH_R);

    for (genvar k = 0; k < NTAPS; k++)
    begin : g_copy
        logic [DATA_W-1:0] mem [TABLE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_ext[IDX_W-1:0]] <= ctl.wr_value;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rd_reg[k] <= mem[addr[k]];
            end
        end
    end

    assign f = rd_reg;

endmodule

@@ hdl/ctip_weights.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctip_weights
// Cubic Lagrange weights for nodes -1, 0, 1, 2 at fraction t, Q27,
// in three stages: pair products, triple products, divide by 2 or 6.
// ----------------------------------------------------------------------------
module ctip_weights
    import ctip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  eval_ctl_t                 in_ctl,
    input  logic [QBITS-1:0]          t,
    output eval_ctl_t                 out_ctl,
    output logic [NTAPS-1:0][WW-1:0]  w
);

    localparam int D_W = PW + 1;
    localparam int M1_W = 2 * PW;
    localparam int M2_W = PW + D_W;
    localparam logic [PW-1:0]  ONE_P = PW'(1) << QBITS;
    localparam logic [D_W-1:0] TWO_D = D_W'(1) << (QBITS + 1);

    eval_ctl_t                 s6_ctl_reg;
    eval_ctl_t                 s7_ctl_reg;
    eval_ctl_t                 s8_ctl_reg;
    logic [QBITS-1:0]          s6_t_reg;
    logic [PW-1:0]             s6_tb_reg;
    logic [PW-1:0]             s6_ab_reg;
    logic [PW-1:0]             s6_at_reg;
    logic [TW-1:0]             s7_tbd_reg;
    logic [TW-1:0]             s7_abd_reg;
    logic [TW-1:0]             s7_atd_reg;
    logic [TW-1:0]             s7_atb_reg;
    logic [NTAPS-1:0][WW-1:0]  s8_w_reg;

    logic [PW-1:0]             a_p;
    logic [PW-1:0]             b_p;
    logic [M1_W-1:0]           tb_full;
    logic [M1_W-1:0]           ab_full;
    logic [M1_W-1:0]           at_full;
    logic [PW-1:0]             b7;
    logic [D_W-1:0]            d7;
    logic [M2_W-1:0]           tbd_full;
    logic [M2_W-1:0]           abd_full;
    logic [M2_W-1:0]           atd_full;
    logic [M2_W-1:0]           atb_full;
    logic [PROD_W-1:0]         q0_full;
    logic [PROD_W-1:0]         q3_full;
    logic [NTAPS-1:0][WW-1:0]  w_next;

    // A = 1 + t, B = 1 - t, D = 2 - t
    assign a_p     = ONE_P + PW'(t);
    assign b_p     = ONE_P - PW'(t);
    assign tb_full = M1_W'(t) * M1_W'(b_p);
    assign ab_full = M1_W'(a_p) * M1_W'(b_p);
    assign at_full = M1_W'(a_p) * M1_W'(t);

    assign b7       = ONE_P - PW'(s6_t_reg);
    assign d7       = TWO_D - D_W'(s6_t_reg);
    assign tbd_full = M2_W'(s6_tb_reg) * M2_W'(d7);
    assign abd_full = M2_W'(s6_ab_reg) * M2_W'(d7);
    assign atd_full = M2_W'(s6_at_reg) * M2_W'(d7);
    assign atb_full = M2_W'(s6_at_reg) * M2_W'(b7);

    // divide by 6: halve, then reciprocal multiply for the 3
    assign q0_full = PROD_W'(s7_tbd_reg[TW-1:1]) * PROD_W'(DIV3_RECIP);
    assign q3_full = PROD_W'(s7_atb_reg[TW-1:1]) * PROD_W'(DIV3_RECIP);

    assign w_next[0] = q0_full[DIV3_SHIFT +: WW];
    assign w_next[1] = s7_abd_reg[1 +: WW];
    assign w_next[2] = s7_atd_reg[1 +: WW];
    assign w_next[3] = q3_full[DIV3_SHIFT +: WW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_ctl_reg <= '0;
            s7_ctl_reg <= '0;
            s8_ctl_reg <= '0;
        end
        else if (en)
        begin
            s6_ctl_reg <= in_ctl;
            s7_ctl_reg <= s6_ctl_reg;
            s8_ctl_reg <= s7_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_t_reg   <= t;
            s6_tb_reg  <= tb_full[QBITS +: PW];
            s6_ab_reg  <= ab_full[QBITS +: PW];
            s6_at_reg  <= at_full[QBITS +: PW];
            s7_tbd_reg <= tbd_full[QBITS +: TW];
            s7_abd_reg <= abd_full[QBITS +: TW];
            s7_atd_reg <= atd_full[QBITS +: TW];
            s7_atb_reg <= atb_full[QBITS +: TW];
            s8_w_reg   <= w_next;
        end
    end

    assign out_ctl = s8_ctl_reg;
    assign w       = s8_w_reg;

endmodule

@@ hdl/ctip_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctip_accum
// Weighted sum of the four neighbors: products, pair sums, total,
// then round half up to Q27 and saturate to 32 bits.
// ----------------------------------------------------------------------------
module ctip_accum
    import ctip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [DATA_W-1:0]         f [NTAPS],
    input  logic [NTAPS-1:0][WW-1:0]  w,
    input  eval_ctl_t                 in_ctl,
    output logic                      res_valid,
    output result_t                   res
);

    localparam int Q_W = ACC_W - QBITS;
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (QBITS - 1);
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic [DATA_W-1:0]         f7_reg [NTAPS];
    logic [DATA_W-1:0]         f8_reg [NTAPS];
    logic signed [ACC_W-1:0]   s9_p_reg [NTAPS];
    logic signed [ACC_W-1:0]   s10_lo_reg;
    logic signed [ACC_W-1:0]   s10_hi_reg;
    logic signed [ACC_W-1:0]   s11_acc_reg;
    result_t                   s12_res_reg;
    eval_ctl_t                 s9_ctl_reg;
    eval_ctl_t                 s10_ctl_reg;
    eval_ctl_t                 s11_ctl_reg;
    eval_ctl_t                 s12_ctl_reg;

    logic signed [ACC_W-1:0]   rsum;
    logic [Q_W-1:0]            q;
    logic                      pos_ovf;
    logic                      neg_ovf;
    result_t                   res_next;

    assign rsum    = s11_acc_reg + ROUND;
    assign q       = rsum[ACC_W-1:QBITS];
    assign pos_ovf = !q[Q_W-1] && (|q[Q_W-2:DATA_W-1]);
    assign neg_ovf = q[Q_W-1] && !(&q[Q_W-2:DATA_W-1]);

    always_comb
    begin
        res_next.out_of_range = s11_ctl_reg.oor;
        if (pos_ovf)
        begin
            res_next.value = SAT_MAX;
        end
        else if (neg_ovf)
        begin
            res_next.value = SAT_MIN;
        end
        else
        begin
            res_next.value = q[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_ctl_reg  <= '0;
            s10_ctl_reg <= '0;
            s11_ctl_reg <= '0;
            s12_ctl_reg <= '0;
        end
        else if (en)
        begin
            s9_ctl_reg  <= in_ctl;
            s10_ctl_reg <= s9_ctl_reg;
            s11_ctl_reg <= s10_ctl_reg;
            s12_ctl_reg <= s11_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NTAPS; k++)
            begin
                f7_reg[k]   <= f[k];
                f8_reg[k]   <= f7_reg[k];
                s9_p_reg[k] <= ACC_W'($signed(f8_reg[k])) * ACC_W'($signed({1'b0, w[k]}));
            end
            // outer taps carry negative weights
            s10_lo_reg  <= s9_p_reg[1] - s9_p_reg[0];
            s10_hi_reg  <= s9_p_reg[2] - s9_p_reg[3];
            s11_acc_reg <= s10_lo_reg + s10_hi_reg;
            s12_res_reg <= res_next;
        end
    end

    assign res_valid = s12_ctl_reg.valid;
    assign res       = s12_res_reg;

endmodule

@@ hdl/cubic_table_interpolator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_table_interpolator_top
// Four-point cubic Lagrange interpolation over a table of uniformly spaced
// Q4.27 samples loaded by write words.
// ----------------------------------------------------------------------------
// The block takes one word per clock when not stalled and returns one result
// per evaluate word; write words load the table and give no result. The rate
// is set by the table, kept in four copies with one read port each, so the
// four neighbors come out of a single read. Writes and reads happen in the
// same stage, so a write is seen by every evaluate that follows it. A two-entry
// output buffer lets the pipeline keep taking words while a result waits;
// input ready drops only when both entries are full. The user must keep
// configuration static while words are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module cubic_table_interpolator_top
    import ctip_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    mode_t                        mode_reg;
    logic [DATA_W-1:0]            scale_reg;
    logic signed [DATA_W-1:0]     offset_reg;

    logic                         out_valid_reg;
    logic                         skid_valid_reg;
    result_t                      out_reg;
    result_t                      skid_reg;

    logic                         en;
    logic                         push;
    tbl_ctl_t                     fr_ctl;
    logic [QBITS-1:0]             fr_t;
    logic                         fr_oor;
    logic [NTAPS-1:0][IDX_W-1:0]  fr_addr;
    logic [DATA_W-1:0]            tbl_f [NTAPS];
    eval_ctl_t                    ev_ctl;
    eval_ctl_t                    wt_ctl;
    logic [NTAPS-1:0][WW-1:0]     wt_w;
    logic                         acc_valid;
    result_t                      acc_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_EVEN;
            scale_reg  <= SCALE_RESET;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_data[0]);
                CFG_SCALE:  scale_reg  <= cfg_data;
                CFG_OFFSET: offset_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign en         = !skid_valid_reg;
    assign item_ready = en;

    ctip_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (item_valid),
        .item       (item),
        .mode       (mode_reg),
        .scale      (scale_reg),
        .offset     (offset_reg),
        .ctl        (fr_ctl),
        .t          (fr_t),
        .oor        (fr_oor),
        .addr       (fr_addr)
    );

    ctip_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .en   (en),
        .ctl  (fr_ctl),
        .addr (fr_addr),
        .f    (tbl_f)
    );

    assign ev_ctl = '{valid: fr_ctl.valid && (fr_ctl.op == OP_EVAL), oor: fr_oor};

    ctip_weights u_weights (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (ev_ctl),
        .t       (fr_t),
        .out_ctl (wt_ctl),
        .w       (wt_w)
    );

    ctip_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .f         (tbl_f),
        .w         (wt_w),
        .in_ctl    (wt_ctl),
        .res_valid (acc_valid),
        .res       (acc_res)
    );

    // output word plus one skid entry
    assign push = en && acc_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : acc_res;
        end
        else if (push)
        begin
            skid_reg <= acc_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cubic table interpolator.
// ----------------------------------------------------------------------------
// Loads the whole sample table, then runs directed words: the mirrored left
// neighbor at index zero, fraction extremes, output saturation, general mode
// with offset extremes, indexes at and past the end of the table, and scale
// extremes. A long output hold-off fills the pipeline. Random words follow,
// with sender gaps and receiver stalls in several mixes. A bit-exact
// fixed-point model predicts every result; a scoreboard checks each result
// word in order.
// ----------------------------------------------------------------------------
module testbench;
    import ctip_pkg::*;

    localparam int TABLE_DEPTH     = DEFAULT_TABLE_DEPTH;
    localparam int DRAIN_CYCLES    = 24;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_WORDS     = 360;

    localparam longint unsigned Q_ONE = 64'd1 << QBITS;

    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic [DATA_W-1:0] SCALE_ONE        = 32'd1 << 20;
    localparam logic [DATA_W-1:0] SCALE_FULL_TABLE = 32'd1 << 25;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result;
    logic              cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data     = '0;

    // model state
    logic signed [DATA_W-1:0] sample_mem [TABLE_DEPTH];
    mode_t                    cur_mode   = MODE_EVEN;
    logic [DATA_W-1:0]        cur_scale  = SCALE_RESET;
    logic signed [DATA_W-1:0] cur_offset = '0;

    result_t pending_results [$];
    int      error_count        = 0;
    int      quiet_cycles       = 0;
    int      sender_idle_pct    = 0;
    int      receiver_stall_pct = 0;
    logic    hold_off_req       = 1'b0;
    logic    hold_off_ack       = 1'b0;
    int      hold_left          = 0;

    cubic_table_interpolator_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned scaled_product(input longint unsigned x,
                                                       input longint unsigned y,
                                                       input longint unsigned z);
        return (((x * y) >> QBITS) * z) >> QBITS;
    endfunction

    function automatic result_t interpolate(input logic signed [DATA_W-1:0] x);
        longint          pos;
        longint          term;
        longint          acc;
        longint          q;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned a1;
        longint unsigned b1;
        longint unsigned b2;
        longint unsigned w   [NTAPS];
        longint unsigned idx [NTAPS];
        result_t         res;
        res = '0;
        pos = longint'(x);
        if (cur_mode == MODE_GENERAL)
            pos += longint'(cur_offset);
        mag   = (pos < 0) ? -pos : pos;
        prod  = mag * cur_scale;
        whole = prod >> 47;
        frac  = (prod >> 20) & (Q_ONE - 1);
        for (int k = 0; k < NTAPS; k++)
        begin
            if (cur_mode == MODE_GENERAL)
                idx[k] = whole + 1 + k;
            else if (whole == 0)
                idx[k] = (k == 1) ? 0 : ((k == 3) ? 2 : 1);   // mirrored neighbor
            else
                idx[k] = whole - 1 + k;
        end
        a1 = Q_ONE + frac;
        b1 = Q_ONE - frac;
        b2 = 2 * Q_ONE - frac;
        w[0] = scaled_product(frac, b1, b2) / 6;
        w[1] = scaled_product(a1, b1, b2) / 2;
        w[2] = scaled_product(a1, frac, b2) / 2;
        w[3] = scaled_product(a1, frac, b1) / 6;
        acc = 0;
        for (int k = 0; k < NTAPS; k++)
        begin
            if (idx[k] >= TABLE_DEPTH)
            begin
                res.out_of_range = 1'b1;
                idx[k] = TABLE_DEPTH - 1;
            end
            term = longint'(sample_mem[idx[k]]) * longint'(w[k]);
            acc += (k == 0 || k == 3) ? -term : term;
        end
        q = (acc + (longint'(1) << 26)) >>> QBITS;
        if (q > longint'(VALUE_MAX))
            q = longint'(VALUE_MAX);
        else if (q < longint'(VALUE_MIN))
            q = longint'(VALUE_MIN);
        res.value = q[DATA_W-1:0];
        return res;
    endfunction

    function automatic item_t write_word(input int unsigned index,
                                         input logic [DATA_W-1:0] value);
        item_t w;
        w.op          = OP_WRITE;
        w.entry_index = index[ENTRY_IDX_W-1:0];
        w.entry_value = value;
        w.sample      = $urandom;
        return w;
    endfunction

    function automatic item_t eval_word(input logic [DATA_W-1:0] x);
        item_t w;
        w.op          = OP_EVAL;
        w.entry_index = ENTRY_IDX_W'($urandom_range(TABLE_DEPTH - 1));
        w.entry_value = $urandom;
        w.sample      = x;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] at_step(input int unsigned whole,
                                                  input int unsigned frac);
        return (whole << QBITS) + frac;
    endfunction

    function automatic logic [DATA_W-1:0] table_value();
        case ($urandom_range(9))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2, 3, 4: return $urandom;
            default: return $urandom_range(32'h1FFF_FFFF) - 32'h1000_0000;
        endcase
    endfunction

    function automatic item_t random_word();
        if ($urandom_range(3) == 0)
            return write_word($urandom_range(TABLE_DEPTH - 1), table_value());
        case ($urandom_range(9))
            0:       return eval_word($urandom_range(32'h0FFF_FFFF));
            1:       return eval_word($urandom_range(1) ? VALUE_MAX : VALUE_MIN);
            2:       return eval_word('0);
            default: return eval_word($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("ERROR at %0t: %s expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    task automatic send_word(input item_t w);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (w.op == OP_EVAL)
            pending_results.push_back(interpolate(w.sample));
        else if (w.entry_index < TABLE_DEPTH)
            sample_mem[w.entry_index] = w.entry_value;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input mode_t m, input logic [DATA_W-1:0] sc,
                              input logic [DATA_W-1:0] off);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= {{(DATA_W - 1){1'b0}}, m};
        @(posedge clk);
        cfg_index <= CFG_SCALE;
        cfg_data  <= sc;
        @(posedge clk);
        cfg_index <= CFG_OFFSET;
        cfg_data  <= off;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_mode   = m;
        cur_scale  = sc;
        cur_offset = off;
    endtask

    task automatic random_config();
        mode_t             m;
        logic [DATA_W-1:0] sc;
        logic [DATA_W-1:0] off;
        m = mode_t'($urandom_range(1));
        case ($urandom_range(7))
            0:       sc = SCALE_ONE;
            1, 2, 3: sc = SCALE_FULL_TABLE;
            4, 5:    sc = $urandom_range(SCALE_ONE, SCALE_FULL_TABLE);
            6:       sc = $urandom_range(SCALE_FULL_TABLE);
            default: sc = $urandom;
        endcase
        case ($urandom_range(3))
            0:       off = '0;
            1:       off = $urandom;
            default: off = $urandom_range(32'h0800_0000) - 32'h0400_0000;
        endcase
        set_config(m, sc, off);
    endtask

    task automatic load_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(write_word(i, table_value()));
    endtask

    // runs on reset register values: even mode, unit scale
    task automatic check_even_mode();
        send_word(eval_word('0));
        send_word(eval_word(at_step(0, 1 << 26)));
        send_word(eval_word(-at_step(3, 0)));
        send_word(eval_word(at_step(3, 32'(Q_ONE - 1))));
        send_word(eval_word(VALUE_MIN));
        send_word(eval_word(VALUE_MAX));
    endtask

    task automatic check_saturation();
        logic signed [DATA_W-1:0] corners [NTAPS];
        corners = '{VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MIN};
        for (int k = 0; k < NTAPS; k++)
        begin
            send_word(write_word(4 + k, corners[k]));
            send_word(write_word(8 + k, ~corners[k]));
        end
        send_word(eval_word(at_step(5, 1 << 26)));
        send_word(eval_word(-at_step(9, 1 << 26)));
    endtask

    task automatic check_general_mode();
        drain();
        set_config(MODE_GENERAL, SCALE_ONE, '0);
        send_word(eval_word('0));
        send_word(eval_word(at_step(1, 1 << 25)));
        drain();
        set_config(MODE_GENERAL, SCALE_ONE, VALUE_MAX);
        send_word(eval_word(VALUE_MAX));
        send_word(eval_word(VALUE_MIN));
        drain();
        set_config(MODE_GENERAL, SCALE_ONE, VALUE_MIN);
        send_word(eval_word(VALUE_MIN));
        drain();
        set_config(MODE_EVEN, SCALE_ONE, 32'h1234_5678);   // offset has no effect
        send_word(eval_word(at_step(2, 1 << 26)));
    endtask

    task automatic check_table_edge();
        drain();
        set_config(MODE_EVEN, SCALE_FULL_TABLE, '0);
        send_word(eval_word(32'd509 << 22));
        send_word(eval_word(32'd510 << 22));
        drain();
        set_config(MODE_GENERAL, SCALE_FULL_TABLE, '0);
        send_word(eval_word(32'd507 << 22));
        send_word(eval_word(32'd508 << 22));
        drain();
        set_config(MODE_EVEN, 32'hFFFF_FFFF, '0);
        send_word(eval_word(VALUE_MAX));
        drain();
        set_config(MODE_GENERAL, '0, VALUE_MAX);
        send_word(eval_word($urandom));
    endtask

    task automatic check_backpressure();
        drain();
        set_config(MODE_EVEN, SCALE_FULL_TABLE, '0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_req <= ~hold_off_req;
        repeat (80) send_word(eval_word($urandom));
        drain();
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int count);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int seg = 0; seg < 4; seg++)
        begin
            drain();
            random_config();
            repeat (count / 4) send_word(random_word());
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_off_req != hold_off_ack)
        begin
            hold_off_ack <= hold_off_req;
            hold_left    <= HOLD_OFF_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with no evaluate pending", 0, result.value);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.value !== want.value)
                    report_mismatch("value", want.value, result.value);
                if (result.out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", want.out_of_range, result.out_of_range);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_table();
        check_even_mode();
        check_saturation();
        check_general_mode();
        check_table_edge();
        check_backpressure();
        run_random(0, 0, PHASE_WORDS);
        run_random(67, 0, PHASE_WORDS);
        run_random(0, 67, PHASE_WORDS);
        run_random(31, 31, PHASE_WORDS);
        drain();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ cubic_table_interpolator_top.f @@
hdl/ctip_pkg.sv
hdl/ctip_front.sv
hdl/ctip_table.sv
hdl/ctip_weights.sv
hdl/ctip_accum.sv
hdl/cubic_table_interpolator_top.sv
tb/sv/testbench.sv
